// ----- rtl/core/sdc_pkg.sv -----
// sdc_pkg: types and constants of the sector DMA disk controller.
// Request structs for both channels, status and error codes, register offsets.
// No dependencies.
package sdc_pkg;

	typedef enum logic [1:0] {
		ST_READY = 2'd0,
		ST_BUSY  = 2'd1,
		ST_ERROR = 2'd2
	} status_t;

	localparam logic [2:0] ERR_NONE     = 3'd0;
	localparam logic [2:0] ERR_NO_MEDIA = 3'd1;
	localparam logic [2:0] ERR_RANGE    = 3'd2;
	localparam logic [2:0] ERR_IO       = 3'd3;
	localparam logic [2:0] ERR_MEMORY   = 3'd4;
	localparam logic [2:0] ERR_READONLY = 3'd5;

	localparam logic [1:0] CMD_BUS_READ  = 2'd0;
	localparam logic [1:0] CMD_BUS_WRITE = 2'd1;
	localparam logic [1:0] CMD_COMPLETE  = 2'd2;

	localparam logic [1:0] OUTCOME_OK     = 2'd0;
	localparam logic [1:0] OUTCOME_MEMORY = 2'd1;

	localparam logic [7:0] OP_IDENTIFY = 8'h01;
	localparam logic [7:0] OP_READ     = 8'h02;
	localparam logic [7:0] OP_WRITE    = 8'h03;

	localparam logic [7:0] OFF_COMMAND  = 8'h00;
	localparam logic [7:0] OFF_STATUS   = 8'h01;
	localparam logic [7:0] OFF_SECT_LO  = 8'h02;
	localparam logic [7:0] OFF_SECT_HI  = 8'h09;
	localparam logic [7:0] OFF_COUNT_LO = 8'h0a;
	localparam logic [7:0] OFF_COUNT_HI = 8'h0b;
	localparam logic [7:0] OFF_BUF_LO   = 8'h0c;
	localparam logic [7:0] OFF_BUF_HI   = 8'h0f;
	localparam logic [7:0] OFF_CAP_LO   = 8'h10;
	localparam logic [7:0] OFF_CAP_HI   = 8'h17;
	localparam logic [7:0] OFF_ERROR    = 8'h18;

	localparam logic [7:0] WIDE_READ_DATA = 8'hff;

	localparam logic [1:0] CFG_MEDIA_PRESENT   = 2'd0;
	localparam logic [1:0] CFG_MEDIA_READ_ONLY = 2'd1;
	localparam logic [1:0] CFG_CAPACITY        = 2'd2;

	localparam int CFG_DATA_W = 48;

	typedef struct packed {
		logic [1:0] command;
		logic [7:0] offset;
		logic [7:0] data;
		logic       byte_access;
		logic [1:0] outcome;
	} in_req_t;

	typedef struct packed {
		logic [7:0]  read_data;
		logic [1:0]  status;
		logic [2:0]  error_code;
		logic        request_valid;
		logic        request_to_disk;
		logic [47:0] request_sector;
		logic [32:0] request_guest_address;
	} out_req_t;

endpackage

// ----- rtl/core/sector_dma_disk_controller.sv -----
// sector_dma_disk_controller: byte-wide register block of a sector disk controller.
// Input register, one combinational pass over the register state, result register.
// Depends on sdc_pkg.
//
// Takes one request per cycle while in_stall is low: bus reads, bus writes and sector
// completion events. A request is captured in an input register and, in the next cycle
// that the result register is free or being drained, resolved against the register state
// in one pass and written to the result register; the sustained rate is one request per
// clock, limited only by downstream stall. Register writes are dropped while a transfer is
// busy; after reset status reads error until an identify or a successful command. Media
// configuration is for the user to write only while idle; the block does not enforce it.
module sector_dma_disk_controller #(
	parameter int SECTOR_BYTES = 512
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wen,
	input  logic [1:0]                    cfg_index,
	input  logic [sdc_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  sdc_pkg::in_req_t              in_req,
	output logic                          out_valid,
	input  logic                          out_stall,
	output sdc_pkg::out_req_t             out_req
);

	logic                media_present_q;
	logic                media_read_only_q;
	logic [47:0]         capacity_q;

	logic                valid_s1;
	sdc_pkg::in_req_t    in_s1;
	logic                out_valid_q;
	sdc_pkg::out_req_t   out_q;

	logic [63:0]         start_sector_q, start_sector_d;
	logic [15:0]         sector_count_q, sector_count_d;
	logic [31:0]         buffer_addr_q, buffer_addr_d;
	sdc_pkg::status_t    status_q, status_d;
	logic [2:0]          fault_q, fault_d;
	logic [15:0]         sector_index_q, sector_index_d;
	logic                direction_q, direction_d;

	logic                advance;
	logic                process;
	logic [47:0]         cap_visible;
	logic [63:0]         cap_wide;
	logic                range_bad;
	logic [15:0]         next_index;
	logic [7:0]          off_sect;
	logic [7:0]          read_byte;
	logic [7:0]          rd_data;
	logic                rv;
	logic                rv_dir;
	logic [15:0]         rv_index;
	logic                to_disk;
	sdc_pkg::out_req_t   result;

	assign advance  = !out_valid_q || !out_stall;
	assign process  = valid_s1 && advance;
	assign in_stall = valid_s1 && !advance;
	assign out_valid = out_valid_q;
	assign out_req   = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			media_present_q   <= 1'b0;
			media_read_only_q <= 1'b0;
			capacity_q        <= '0;
		end else if (cfg_wen) begin
			case (cfg_index)
				sdc_pkg::CFG_MEDIA_PRESENT:   media_present_q   <= cfg_data[0];
				sdc_pkg::CFG_MEDIA_READ_ONLY: media_read_only_q <= cfg_data[0];
				sdc_pkg::CFG_CAPACITY:        capacity_q        <= cfg_data[47:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			in_s1 <= in_req;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (process) begin
			out_q <= result;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_sector_q <= '0;
			sector_count_q <= '0;
			buffer_addr_q  <= '0;
			status_q       <= sdc_pkg::ST_ERROR;
			fault_q        <= sdc_pkg::ERR_NONE;
			sector_index_q <= '0;
			direction_q    <= 1'b0;
		end else if (process) begin
			start_sector_q <= start_sector_d;
			sector_count_q <= sector_count_d;
			buffer_addr_q  <= buffer_addr_d;
			status_q       <= status_d;
			fault_q        <= fault_d;
			sector_index_q <= sector_index_d;
			direction_q    <= direction_d;
		end
	end

	assign cap_visible = media_present_q ? capacity_q : '0;
	assign cap_wide    = {16'd0, cap_visible};
	assign range_bad   = (sector_count_q == 16'd0) || (start_sector_q > cap_wide) ||
		({32'd0, sector_count_q} > (cap_visible - start_sector_q[47:0]));
	assign next_index  = sector_index_q + 16'd1;
	assign off_sect    = in_s1.offset - sdc_pkg::OFF_SECT_LO;
	assign to_disk     = (in_s1.data == sdc_pkg::OP_WRITE);

	always_comb begin
		read_byte = 8'd0;
		if (in_s1.offset == sdc_pkg::OFF_STATUS) begin
			read_byte = {6'd0, status_q};
		end else if (in_s1.offset == sdc_pkg::OFF_ERROR) begin
			read_byte = {5'd0, fault_q};
		end else if (in_s1.offset >= sdc_pkg::OFF_CAP_LO &&
				in_s1.offset <= sdc_pkg::OFF_CAP_HI) begin
			read_byte = cap_wide[{in_s1.offset[2:0], 3'd0} +: 8];
		end else if (in_s1.offset >= sdc_pkg::OFF_SECT_LO &&
				in_s1.offset <= sdc_pkg::OFF_SECT_HI) begin
			read_byte = start_sector_q[{off_sect[2:0], 3'd0} +: 8];
		end else if (in_s1.offset == sdc_pkg::OFF_COUNT_LO) begin
			read_byte = sector_count_q[7:0];
		end else if (in_s1.offset == sdc_pkg::OFF_COUNT_HI) begin
			read_byte = sector_count_q[15:8];
		end else if (in_s1.offset >= sdc_pkg::OFF_BUF_LO &&
				in_s1.offset <= sdc_pkg::OFF_BUF_HI) begin
			read_byte = buffer_addr_q[{in_s1.offset[1:0], 3'd0} +: 8];
		end
	end

	always_comb begin
		start_sector_d = start_sector_q;
		sector_count_d = sector_count_q;
		buffer_addr_d  = buffer_addr_q;
		status_d       = status_q;
		fault_d        = fault_q;
		sector_index_d = sector_index_q;
		direction_d    = direction_q;
		rd_data        = 8'd0;
		rv             = 1'b0;
		rv_dir         = direction_q;
		rv_index       = sector_index_q;
		case (in_s1.command)
			sdc_pkg::CMD_BUS_READ: begin
				rd_data = in_s1.byte_access ? read_byte : sdc_pkg::WIDE_READ_DATA;
			end
			sdc_pkg::CMD_BUS_WRITE: begin
				if (in_s1.byte_access && status_q != sdc_pkg::ST_BUSY) begin
					if (in_s1.offset == sdc_pkg::OFF_COMMAND) begin
						if (in_s1.data == sdc_pkg::OP_IDENTIFY) begin
							status_d = sdc_pkg::ST_READY;
							fault_d  = sdc_pkg::ERR_NONE;
						end else if (in_s1.data == sdc_pkg::OP_READ ||
								in_s1.data == sdc_pkg::OP_WRITE) begin
							status_d = sdc_pkg::ST_ERROR;
							if (!media_present_q) begin
								fault_d = sdc_pkg::ERR_NO_MEDIA;
							end else if (range_bad) begin
								fault_d = sdc_pkg::ERR_RANGE;
							end else if (to_disk && media_read_only_q) begin
								fault_d = sdc_pkg::ERR_READONLY;
							end else begin
								status_d       = sdc_pkg::ST_BUSY;
								fault_d        = sdc_pkg::ERR_NONE;
								direction_d    = to_disk;
								sector_index_d = '0;
								rv             = 1'b1;
								rv_dir         = to_disk;
								rv_index       = '0;
							end
						end else begin
							status_d = sdc_pkg::ST_ERROR;
							fault_d  = sdc_pkg::ERR_IO;
						end
					end else if (in_s1.offset >= sdc_pkg::OFF_SECT_LO &&
							in_s1.offset <= sdc_pkg::OFF_SECT_HI) begin
						start_sector_d[{off_sect[2:0], 3'd0} +: 8] = in_s1.data;
					end else if (in_s1.offset == sdc_pkg::OFF_COUNT_LO) begin
						sector_count_d[7:0] = in_s1.data;
					end else if (in_s1.offset == sdc_pkg::OFF_COUNT_HI) begin
						sector_count_d[15:8] = in_s1.data;
					end else if (in_s1.offset >= sdc_pkg::OFF_BUF_LO &&
							in_s1.offset <= sdc_pkg::OFF_BUF_HI) begin
						buffer_addr_d[{in_s1.offset[1:0], 3'd0} +: 8] = in_s1.data;
					end
				end
			end
			sdc_pkg::CMD_COMPLETE: begin
				if (status_q == sdc_pkg::ST_BUSY) begin
					if (in_s1.outcome == sdc_pkg::OUTCOME_MEMORY) begin
						status_d = sdc_pkg::ST_ERROR;
						fault_d  = sdc_pkg::ERR_MEMORY;
					end else if (in_s1.outcome != sdc_pkg::OUTCOME_OK) begin
						status_d = sdc_pkg::ST_ERROR;
						fault_d  = sdc_pkg::ERR_IO;
					end else begin
						sector_index_d = next_index;
						if (next_index >= sector_count_q) begin
							status_d = sdc_pkg::ST_READY;
						end else begin
							rv       = 1'b1;
							rv_index = next_index;
						end
					end
				end
			end
			default: ;
		endcase
	end

	always_comb begin
		result.read_data       = rd_data;
		result.status          = status_d;
		result.error_code      = fault_d;
		result.request_valid   = rv;
		result.request_to_disk = rv && rv_dir;
		result.request_sector  = rv ? (start_sector_q[47:0] + {32'd0, rv_index}) : '0;
		result.request_guest_address = rv ?
			({1'b0, buffer_addr_q} + (33'(rv_index) * 33'(SECTOR_BYTES))) : '0;
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.request_valid |-> out_q.status == sdc_pkg::ST_BUSY)
		else $error("sector request issued without busy status");

	assert property (@(posedge clk) disable iff (!arst_n)
		status_q == sdc_pkg::ST_BUSY |-> sector_index_q < sector_count_q)
		else $error("busy with sector index past sector count");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_q.request_valid |->
			out_q.request_sector == '0 && out_q.request_guest_address == '0 &&
			!out_q.request_to_disk)
		else $error("request fields set without a request");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_stall |=> out_valid_q && $stable(out_q))
		else $error("stalled result changed");

endmodule
